[sv/hda_codec_enumeration_sequencer_macros.svh]
// Assertion macros for the checker of the codec enumeration sequencer.
`ifndef HDA_CODEC_ENUMERATION_SEQUENCER_MACROS_SVH
`define HDA_CODEC_ENUMERATION_SEQUENCER_MACROS_SVH

// Check a property on every rising edge of clk, with the check off while in reset.
`define HCES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that post holds in the cycle after pre.
`define HCES_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[sv/hces_pkg.sv]
package hces_pkg;

  // Default walk limits
  localparam int DEF_MAX_GROUPS  = 4;
  localparam int DEF_MAX_WIDGETS = 64;
  localparam int DEF_NUM_SLOTS   = 15;

  // Verbs and parameter IDs
  localparam logic [11:0] VERB_GET_PARAM = 12'hF00;
  localparam logic [11:0] VERB_GET_CONN  = 12'hF02;
  localparam logic [7:0]  PRM_VENDOR     = 8'h00;
  localparam logic [7:0]  PRM_REVISION   = 8'h02;
  localparam logic [7:0]  PRM_SUBNODES   = 8'h04;
  localparam logic [7:0]  PRM_FG_TYPE    = 8'h05;
  localparam logic [7:0]  PRM_WCAPS      = 8'h09;
  localparam logic [7:0]  PRM_AMP_IN     = 8'h0D;
  localparam logic [7:0]  PRM_CONN_LEN   = 8'h0E;
  localparam logic [7:0]  PRM_AMP_OUT    = 8'h12;
  localparam logic [7:0]  CONN_ENTRY0    = 8'h00;
  localparam logic [6:0]  FG_AUDIO       = 7'h01;

  // Widget type codes
  localparam logic [3:0] WT_AUDIO_OUT = 4'h0;
  localparam logic [3:0] WT_AUDIO_IN  = 4'h1;
  localparam logic [3:0] WT_PIN       = 4'h4;

  // Result kinds
  localparam logic KIND_VERB    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Item ops
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // One result beat
  typedef struct packed {
    logic        kind;
    logic [31:0] verb_word;
    logic [31:0] root_vendor;
    logic [2:0]  audio_groups;
    logic [8:0]  dac_count;
    logic [8:0]  adc_count;
    logic [8:0]  pin_count;
    logic [8:0]  amp_count;
    logic [14:0] conn_len_sum;
    logic [8:0]  conn_read_count;
  } result_t;

endpackage

[sv/hda_codec_enumeration_sequencer.sv]
// Codec enumeration sequencer.
// Input channel (in_valid_i / in_stall_o): a start beat (op_i = 0) names a codec slot
// in codec_slot_i; every later beat (op_i = 1) carries the codec response in
// response_i, with 0 standing for a timeout.
// Output channel (out_valid_o / out_stall_i): each beat is either the next verb to
// send (out_kind_o = 0, verb_word_o) or the final summary (out_kind_o = 1). A
// response beat that arrives while no walk is running gives no output beat.
// An accepted input beat is held in the input register, and the walk's result
// for it is loaded into the output register as it leaves. Throughput: one beat per
// cycle while the receiver does not stall. The walk state sits in one register set
// that is updated as each beat leaves the input register, so beats may follow back
// to back. When the receiver stalls, the result holds in the output register, one
// more beat waits in the input register, and only then does in_stall_o rise.
// Reset clears both valid bits and returns the walk to idle; no clearing pass.
module hda_codec_enumeration_sequencer #(
  parameter int MAX_GROUPS  = hces_pkg::DEF_MAX_GROUPS,
  parameter int MAX_WIDGETS = hces_pkg::DEF_MAX_WIDGETS,
  parameter int NUM_SLOTS   = hces_pkg::DEF_NUM_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [3:0]  codec_slot_i,
  input  logic [31:0] response_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [31:0] verb_word_o,
  output logic [31:0] root_vendor_o,
  output logic [2:0]  audio_groups_o,
  output logic [8:0]  dac_count_o,
  output logic [8:0]  adc_count_o,
  output logic [8:0]  pin_count_o,
  output logic [8:0]  amp_count_o,
  output logic [14:0] conn_len_sum_o,
  output logic [8:0]  conn_read_count_o
);
  import hces_pkg::*;

  logic        in_valid_q;
  logic        op_q;
  logic [3:0]  slot_q;
  logic [31:0] resp_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        in_fire;
  logic        adv;
  logic        res_valid;
  result_t     res;

  // Move the input beat on when the output register is free or being drained
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  hces_walk #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_WIDGETS(MAX_WIDGETS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .op_i       (op_q),
    .slot_i     (slot_q),
    .resp_i     (resp_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_i;
      slot_q <= codec_slot_i;
      resp_q <= response_i;
    end
  end

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_q.kind;
  assign verb_word_o       = out_q.verb_word;
  assign root_vendor_o     = out_q.root_vendor;
  assign audio_groups_o    = out_q.audio_groups;
  assign dac_count_o       = out_q.dac_count;
  assign adc_count_o       = out_q.adc_count;
  assign pin_count_o       = out_q.pin_count;
  assign amp_count_o       = out_q.amp_count;
  assign conn_len_sum_o    = out_q.conn_len_sum;
  assign conn_read_count_o = out_q.conn_read_count;

endmodule

[sv/hces_walk.sv]
module hces_walk #(
  parameter int MAX_GROUPS  = hces_pkg::DEF_MAX_GROUPS,
  parameter int MAX_WIDGETS = hces_pkg::DEF_MAX_WIDGETS,
  parameter int NUM_SLOTS   = hces_pkg::DEF_NUM_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              op_i,
  input  logic [3:0]        slot_i,
  input  logic [31:0]       resp_i,
  output logic              res_valid_o,
  output hces_pkg::result_t res_o
);
  import hces_pkg::*;

  localparam int GrpW = $clog2(MAX_GROUPS + 1);
  localparam int WgtW = $clog2(MAX_WIDGETS + 1);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_VENDOR  = 4'd1;
  localparam logic [3:0] PH_REV     = 4'd2;
  localparam logic [3:0] PH_ROOT    = 4'd3;
  localparam logic [3:0] PH_FGTYPE  = 4'd4;
  localparam logic [3:0] PH_FGSUB   = 4'd5;
  localparam logic [3:0] PH_CAPS    = 4'd6;
  localparam logic [3:0] PH_INAMP   = 4'd7;
  localparam logic [3:0] PH_OUTAMP  = 4'd8;
  localparam logic [3:0] PH_CONNLEN = 4'd9;
  localparam logic [3:0] PH_CONNENT = 4'd10;

  function automatic logic [8:0] sat_inc9(input logic [8:0] v);
    return (v == 9'h1FF) ? v : v + 9'd1;
  endfunction

  logic [3:0]      phase_q, phase_d;
  logic [3:0]      slot_q, slot_d;
  logic [7:0]      g_start_q, g_start_d;
  logic [GrpW-1:0] g_lim_q, g_lim_d;
  logic [GrpW-1:0] g_idx_q, g_idx_d;
  logic [7:0]      w_start_q, w_start_d;
  logic [WgtW-1:0] w_lim_q, w_lim_d;
  logic [WgtW-1:0] w_idx_q, w_idx_d;
  logic [2:0]      caps_q, caps_d;
  logic [31:0]     vendor_q, vendor_d;
  logic [2:0]      groups_q, groups_d;
  logic [8:0]      dac_q, dac_d;
  logic [8:0]      adc_q, adc_d;
  logic [8:0]      pin_q, pin_d;
  logic [8:0]      amp_q, amp_d;
  logic [14:0]     conn_q, conn_d;
  logic [8:0]      reads_q, reads_d;

  // Step control
  logic        emit, summ, nw, qw, ng, qg;
  logic [7:0]  e_node;
  logic [11:0] e_verb;
  logic [7:0]  e_data;
  logic [3:0]  e_phase;
  logic [7:0]  wnode;
  logic [7:0]  cnt8;
  logic [6:0]  len7;
  logic [15:0] conn_sum;
  logic [2:0]  flags;

  assign wnode    = w_start_q + 8'(w_idx_q);
  assign cnt8     = resp_i[7:0];
  assign len7     = resp_i[6:0];
  assign conn_sum = {1'b0, conn_q} + 16'(len7);
  assign flags    = {resp_i[8], resp_i[2], resp_i[1]};

  // Work out the next state and the result of one item
  always_comb begin
    phase_d   = phase_q;
    slot_d    = slot_q;
    g_start_d = g_start_q;
    g_lim_d   = g_lim_q;
    g_idx_d   = g_idx_q;
    w_start_d = w_start_q;
    w_lim_d   = w_lim_q;
    w_idx_d   = w_idx_q;
    caps_d    = caps_q;
    vendor_d  = vendor_q;
    groups_d  = groups_q;
    dac_d     = dac_q;
    adc_d     = adc_q;
    pin_d     = pin_q;
    amp_d     = amp_q;
    conn_d    = conn_q;
    reads_d   = reads_q;
    emit      = 1'b0;
    summ      = 1'b0;
    nw        = 1'b0;
    qw        = 1'b0;
    ng        = 1'b0;
    qg        = 1'b0;
    e_node    = 8'd0;
    e_verb    = VERB_GET_PARAM;
    e_data    = PRM_VENDOR;
    e_phase   = PH_IDLE;

    if (op_i == OP_START) begin
      // Abandon any run and begin at the root, or give a summary if the slot is out of range
      g_start_d = '0;
      g_lim_d   = '0;
      g_idx_d   = '0;
      w_start_d = '0;
      w_lim_d   = '0;
      w_idx_d   = '0;
      caps_d    = '0;
      vendor_d  = '0;
      groups_d  = '0;
      dac_d     = '0;
      adc_d     = '0;
      pin_d     = '0;
      amp_d     = '0;
      conn_d    = '0;
      reads_d   = '0;
      if (slot_i >= 4'(NUM_SLOTS)) begin
        slot_d = '0;
        summ   = 1'b1;
      end else begin
        slot_d  = slot_i;
        emit    = 1'b1;
        e_data  = PRM_VENDOR;
        e_phase = PH_VENDOR;
      end
    end else begin
      case (phase_q)
        PH_VENDOR: begin
          vendor_d = resp_i;
          if (resp_i == 32'd0) begin
            summ = 1'b1;
          end else begin
            emit    = 1'b1;
            e_data  = PRM_REVISION;
            e_phase = PH_REV;
          end
        end
        PH_REV: begin
          emit    = 1'b1;
          e_data  = PRM_SUBNODES;
          e_phase = PH_ROOT;
        end
        PH_ROOT: begin
          g_start_d = resp_i[23:16];
          if (cnt8 == 8'd0 || resp_i[23:16] == 8'd0) begin
            summ = 1'b1;
          end else begin
            g_lim_d = (cnt8 > 8'(MAX_GROUPS)) ? GrpW'(MAX_GROUPS) : GrpW'(cnt8);
            g_idx_d = '0;
            qg      = 1'b1;
          end
        end
        PH_FGTYPE: begin
          if (len7 != FG_AUDIO) begin
            ng = 1'b1;
          end else begin
            groups_d = (groups_q == 3'd7) ? groups_q : groups_q + 3'd1;
            emit     = 1'b1;
            e_node   = g_start_q + 8'(g_idx_q);
            e_data   = PRM_SUBNODES;
            e_phase  = PH_FGSUB;
          end
        end
        PH_FGSUB: begin
          w_start_d = resp_i[23:16];
          w_lim_d   = (cnt8 > 8'(MAX_WIDGETS)) ? WgtW'(MAX_WIDGETS) : WgtW'(cnt8);
          w_idx_d   = '0;
          qw        = 1'b1;
        end
        PH_CAPS: begin
          case (resp_i[23:20])
            WT_AUDIO_OUT: dac_d = sat_inc9(dac_q);
            WT_AUDIO_IN:  adc_d = sat_inc9(adc_q);
            WT_PIN:       pin_d = sat_inc9(pin_q);
            default:      ;
          endcase
          caps_d = flags;
          if (flags[1:0] != 2'b00) amp_d = sat_inc9(amp_q);
          e_node = wnode;
          if (flags[0]) begin
            emit    = 1'b1;
            e_data  = PRM_AMP_IN;
            e_phase = PH_INAMP;
          end else if (flags[1]) begin
            emit    = 1'b1;
            e_data  = PRM_AMP_OUT;
            e_phase = PH_OUTAMP;
          end else if (flags[2]) begin
            emit    = 1'b1;
            e_data  = PRM_CONN_LEN;
            e_phase = PH_CONNLEN;
          end else begin
            nw = 1'b1;
          end
        end
        PH_INAMP: begin
          e_node = wnode;
          if (caps_q[1]) begin
            emit    = 1'b1;
            e_data  = PRM_AMP_OUT;
            e_phase = PH_OUTAMP;
          end else if (caps_q[2]) begin
            emit    = 1'b1;
            e_data  = PRM_CONN_LEN;
            e_phase = PH_CONNLEN;
          end else begin
            nw = 1'b1;
          end
        end
        PH_OUTAMP: begin
          e_node = wnode;
          if (caps_q[2]) begin
            emit    = 1'b1;
            e_data  = PRM_CONN_LEN;
            e_phase = PH_CONNLEN;
          end else begin
            nw = 1'b1;
          end
        end
        PH_CONNLEN: begin
          conn_d = conn_sum[15] ? 15'h7FFF : conn_sum[14:0];
          if (len7 != 7'd0) begin
            emit    = 1'b1;
            e_node  = wnode;
            e_verb  = VERB_GET_CONN;
            e_data  = CONN_ENTRY0;
            e_phase = PH_CONNENT;
          end else begin
            nw = 1'b1;
          end
        end
        PH_CONNENT: begin
          if (resp_i != 32'd0) reads_d = sat_inc9(reads_q);
          nw = 1'b1;
        end
        default: ;
      endcase
    end

    // Advance to the next widget, then fall back to the next group
    if (nw) begin
      w_idx_d = w_idx_q + WgtW'(1);
      qw      = 1'b1;
    end
    if (qw) begin
      if (w_idx_d < w_lim_d) begin
        emit    = 1'b1;
        e_node  = w_start_d + 8'(w_idx_d);
        e_verb  = VERB_GET_PARAM;
        e_data  = PRM_WCAPS;
        e_phase = PH_CAPS;
      end else begin
        ng = 1'b1;
      end
    end
    if (ng) begin
      g_idx_d = g_idx_q + GrpW'(1);
      qg      = 1'b1;
    end
    if (qg) begin
      if (g_idx_d < g_lim_d) begin
        emit    = 1'b1;
        e_node  = g_start_d + 8'(g_idx_d);
        e_verb  = VERB_GET_PARAM;
        e_data  = PRM_FG_TYPE;
        e_phase = PH_FGTYPE;
      end else begin
        summ = 1'b1;
      end
    end

    phase_d = summ ? PH_IDLE : (emit ? e_phase : phase_q);
  end

  // Form the result beat
  always_comb begin
    res_valid_o = fire_i && (emit || summ);
    res_o       = '0;
    if (summ) begin
      res_o.kind            = KIND_SUMMARY;
      res_o.root_vendor     = vendor_d;
      res_o.audio_groups    = groups_d;
      res_o.dac_count       = dac_d;
      res_o.adc_count       = adc_d;
      res_o.pin_count       = pin_d;
      res_o.amp_count       = amp_d;
      res_o.conn_len_sum    = conn_d;
      res_o.conn_read_count = reads_d;
    end else begin
      res_o.kind      = KIND_VERB;
      res_o.verb_word = {slot_d, e_node, e_verb, e_data};
    end
  end

  // Commit state on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      slot_q    <= '0;
      g_start_q <= '0;
      g_lim_q   <= '0;
      g_idx_q   <= '0;
      w_start_q <= '0;
      w_lim_q   <= '0;
      w_idx_q   <= '0;
      caps_q    <= '0;
      vendor_q  <= '0;
      groups_q  <= '0;
      dac_q     <= '0;
      adc_q     <= '0;
      pin_q     <= '0;
      amp_q     <= '0;
      conn_q    <= '0;
      reads_q   <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      slot_q    <= slot_d;
      g_start_q <= g_start_d;
      g_lim_q   <= g_lim_d;
      g_idx_q   <= g_idx_d;
      w_start_q <= w_start_d;
      w_lim_q   <= w_lim_d;
      w_idx_q   <= w_idx_d;
      caps_q    <= caps_d;
      vendor_q  <= vendor_d;
      groups_q  <= groups_d;
      dac_q     <= dac_d;
      adc_q     <= adc_d;
      pin_q     <= pin_d;
      amp_q     <= amp_d;
      conn_q    <= conn_d;
      reads_q   <= reads_d;
    end
  end

endmodule

[sv/hces_checker.sv]
`include "hda_codec_enumeration_sequencer_macros.svh"

module hces_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_kind_o,
  input logic [31:0] verb_word_o,
  input logic [31:0] root_vendor_o,
  input logic [2:0]  audio_groups_o,
  input logic [8:0]  dac_count_o,
  input logic [8:0]  adc_count_o,
  input logic [8:0]  pin_count_o,
  input logic [8:0]  amp_count_o,
  input logic [14:0] conn_len_sum_o,
  input logic [8:0]  conn_read_count_o
);
  import hces_pkg::*;

  logic out_held;
  logic verb_out;
  logic sum_out;
  logic counts_zero;

  assign out_held    = out_valid_o && out_stall_i;
  assign verb_out    = out_valid_o && out_kind_o == KIND_VERB;
  assign sum_out     = out_valid_o && out_kind_o == KIND_SUMMARY;
  assign counts_zero = root_vendor_o == 32'd0 && audio_groups_o == 3'd0 &&
                       dac_count_o == 9'd0 && adc_count_o == 9'd0 &&
                       pin_count_o == 9'd0 && amp_count_o == 9'd0 &&
                       conn_len_sum_o == 15'd0 && conn_read_count_o == 9'd0;

  // A stalled output beat stays up
  `HCES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o, "stalled beat dropped")

  // A verb beat carries no summary counts
  `HCES_ASSERT(a_verb_clean, clk_i, rst_ni, !verb_out || counts_zero, "verb beat with counts set")

  // A summary beat carries no verb
  `HCES_ASSERT(a_sum_clean, clk_i, rst_ni, !sum_out || verb_word_o == 32'd0, "summary with verb")

  // A verb never addresses the broadcast codec slot
  `HCES_ASSERT(a_slot_range, clk_i, rst_ni, !verb_out || verb_word_o[31:28] != 4'hF, "verb to slot 15")

endmodule

bind hda_codec_enumeration_sequencer hces_checker u_hces_checker (.*);

[sim/hces_walk_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the codec enumeration sequencer, predicts every output beat
// from the accepted input beats and compares the two in order.
module hces_walk_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        op_i,
  input  logic [3:0]  codec_slot_i,
  input  logic [31:0] response_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        out_kind_o,
  input  logic [31:0] verb_word_o,
  input  logic [31:0] root_vendor_o,
  input  logic [2:0]  audio_groups_o,
  input  logic [8:0]  dac_count_o,
  input  logic [8:0]  adc_count_o,
  input  logic [8:0]  pin_count_o,
  input  logic [8:0]  amp_count_o,
  input  logic [14:0] conn_len_sum_o,
  input  logic [8:0]  conn_read_count_o,
  output int          fail_count_o,
  output int          pending_o
);
  import hces_pkg::*;

  typedef enum logic [3:0] {
    WALK_IDLE, WALK_VENDOR, WALK_REV, WALK_ROOT, WALK_FG_TYPE, WALK_FG_SUB,
    WALK_CAPS, WALK_IN_AMP, WALK_OUT_AMP, WALK_CONN_LEN, WALK_CONN_ENT
  } walk_phase_e;

  // Predicted walk state
  walk_phase_e walk_phase;
  logic [3:0]  cur_slot;
  logic [7:0]  grp_base;
  logic [2:0]  grp_lim;
  logic [2:0]  grp_idx;
  logic [7:0]  wid_base;
  logic [6:0]  wid_lim;
  logic [6:0]  wid_idx;
  logic [2:0]  amp_flags;    // bit0 input amp, bit1 output amp, bit2 connection list
  logic [31:0] vendor;
  logic [2:0]  audio_total;
  logic [8:0]  dac_total;
  logic [8:0]  adc_total;
  logic [8:0]  pin_total;
  logic [8:0]  amp_total;
  logic [14:0] list_len_total;
  logic [8:0]  conn_reads;

  result_t expected_beats[$];

  function automatic logic [8:0] bump9(input logic [8:0] v);
    return (v == '1) ? v : v + 9'd1;
  endfunction

  task automatic forget_walk();
    grp_base = '0;
    grp_lim = '0;
    grp_idx = '0;
    wid_base = '0;
    wid_lim = '0;
    wid_idx = '0;
    amp_flags = '0;
    vendor = '0;
    audio_total = '0;
    dac_total = '0;
    adc_total = '0;
    pin_total = '0;
    amp_total = '0;
    list_len_total = '0;
    conn_reads = '0;
  endtask

  task automatic issue_verb(input logic [7:0] node, input logic [11:0] verb,
                            input logic [7:0] data, input walk_phase_e next);
    result_t beat;
    beat = '0;
    beat.kind = KIND_VERB;
    beat.verb_word = {cur_slot, node, verb, data};
    expected_beats.push_back(beat);
    walk_phase = next;
  endtask

  task automatic close_walk();
    result_t beat;
    beat = '0;
    beat.kind = KIND_SUMMARY;
    beat.root_vendor = vendor;
    beat.audio_groups = audio_total;
    beat.dac_count = dac_total;
    beat.adc_count = adc_total;
    beat.pin_count = pin_total;
    beat.amp_count = amp_total;
    beat.conn_len_sum = list_len_total;
    beat.conn_read_count = conn_reads;
    expected_beats.push_back(beat);
    walk_phase = WALK_IDLE;
  endtask

  task automatic try_group();
    if (grp_idx < grp_lim) begin
      issue_verb(grp_base + grp_idx, VERB_GET_PARAM, PRM_FG_TYPE, WALK_FG_TYPE);
    end else begin
      close_walk();
    end
  endtask

  task automatic step_group();
    grp_idx = grp_idx + 3'd1;
    try_group();
  endtask

  task automatic try_widget();
    if (wid_idx < wid_lim) begin
      issue_verb(wid_base + wid_idx, VERB_GET_PARAM, PRM_WCAPS, WALK_CAPS);
    end else begin
      step_group();
    end
  endtask

  task automatic step_widget();
    wid_idx = wid_idx + 7'd1;
    try_widget();
  endtask

  task automatic after_amps();
    if (amp_flags[2]) begin
      issue_verb(wid_base + wid_idx, VERB_GET_PARAM, PRM_CONN_LEN, WALK_CONN_LEN);
    end else begin
      step_widget();
    end
  endtask

  task automatic after_in_amp();
    if (amp_flags[1]) begin
      issue_verb(wid_base + wid_idx, VERB_GET_PARAM, PRM_AMP_OUT, WALK_OUT_AMP);
    end else begin
      after_amps();
    end
  endtask

  // Advance the walk by one input beat and queue the beat it should produce
  task automatic predict_beat(input logic op, input logic [3:0] slot,
                              input logic [31:0] word);
    logic [7:0]  cnt;
    logic [15:0] sum;
    if (op == OP_START) begin
      forget_walk();
      if (slot >= DEF_NUM_SLOTS) begin
        cur_slot = '0;
        close_walk();
      end else begin
        cur_slot = slot;
        issue_verb(8'h00, VERB_GET_PARAM, PRM_VENDOR, WALK_VENDOR);
      end
      return;
    end
    cnt = word[7:0];
    case (walk_phase)
      WALK_VENDOR: begin
        vendor = word;
        if (word == '0) close_walk();
        else issue_verb(8'h00, VERB_GET_PARAM, PRM_REVISION, WALK_REV);
      end
      WALK_REV: begin
        issue_verb(8'h00, VERB_GET_PARAM, PRM_SUBNODES, WALK_ROOT);
      end
      WALK_ROOT: begin
        grp_base = word[23:16];
        if (cnt == '0 || grp_base == '0) begin
          close_walk();
        end else begin
          grp_lim = (cnt > DEF_MAX_GROUPS) ? 3'(DEF_MAX_GROUPS) : cnt[2:0];
          grp_idx = '0;
          try_group();
        end
      end
      WALK_FG_TYPE: begin
        // skip anything that is not an audio group
        if (word[6:0] != FG_AUDIO) begin
          step_group();
        end else begin
          if (audio_total != '1) audio_total = audio_total + 3'd1;
          issue_verb(grp_base + grp_idx, VERB_GET_PARAM, PRM_SUBNODES, WALK_FG_SUB);
        end
      end
      WALK_FG_SUB: begin
        wid_base = word[23:16];
        wid_lim = (cnt > DEF_MAX_WIDGETS) ? 7'(DEF_MAX_WIDGETS) : cnt[6:0];
        wid_idx = '0;
        try_widget();
      end
      WALK_CAPS: begin
        case (word[23:20])
          WT_AUDIO_OUT: dac_total = bump9(dac_total);
          WT_AUDIO_IN:  adc_total = bump9(adc_total);
          WT_PIN:       pin_total = bump9(pin_total);
          default: ;
        endcase
        amp_flags = {word[8], word[2], word[1]};
        if (amp_flags[1:0] != '0) amp_total = bump9(amp_total);
        if (amp_flags[0]) begin
          issue_verb(wid_base + wid_idx, VERB_GET_PARAM, PRM_AMP_IN, WALK_IN_AMP);
        end else begin
          after_in_amp();
        end
      end
      WALK_IN_AMP: after_in_amp();
      WALK_OUT_AMP: after_amps();
      WALK_CONN_LEN: begin
        sum = {1'b0, list_len_total} + {9'd0, word[6:0]};
        list_len_total = sum[15] ? '1 : sum[14:0];
        if (word[6:0] != '0) begin
          issue_verb(wid_base + wid_idx, VERB_GET_CONN, CONN_ENTRY0, WALK_CONN_ENT);
        end else begin
          step_widget();
        end
      end
      WALK_CONN_ENT: begin
        if (word != '0) conn_reads = bump9(conn_reads);
        step_widget();
      end
      // a response with no walk running is dropped
      default: ;
    endcase
  endtask

  task automatic check_field(input string tag, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, tag, want, got);
      fail_count_o++;
    end
  endtask

  // Compare one output beat against the oldest prediction
  task automatic check_beat();
    result_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t: output beat with nothing expected: kind %b verb %h",
               $time, out_kind_o, verb_word_o);
      fail_count_o++;
      return;
    end
    want = expected_beats.pop_front();
    check_field("out_kind", 32'(want.kind), 32'(out_kind_o));
    check_field("verb_word", want.verb_word, verb_word_o);
    check_field("root_vendor", want.root_vendor, root_vendor_o);
    check_field("audio_groups", 32'(want.audio_groups), 32'(audio_groups_o));
    check_field("dac_count", 32'(want.dac_count), 32'(dac_count_o));
    check_field("adc_count", 32'(want.adc_count), 32'(adc_count_o));
    check_field("pin_count", 32'(want.pin_count), 32'(pin_count_o));
    check_field("amp_count", 32'(want.amp_count), 32'(amp_count_o));
    check_field("conn_len_sum", 32'(want.conn_len_sum), 32'(conn_len_sum_o));
    check_field("conn_read_count", 32'(want.conn_read_count), 32'(conn_read_count_o));
  endtask

  // Retire the output beat first, then predict from the input beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_phase = WALK_IDLE;
      cur_slot = '0;
      forget_walk();
      expected_beats.delete();
    end else begin
      if (out_valid_o && !out_stall_i) check_beat();
      if (in_valid_i && !in_stall_o) predict_beat(op_i, codec_slot_i, response_i);
    end
    pending_o = expected_beats.size();
  end

endmodule

[sim/hda_codec_enumeration_sequencer_test.sv]
`timescale 1ns / 100ps

// Drives codec walks into the enumeration sequencer and gives the verdict.
module hda_codec_enumeration_sequencer_test;
  import hces_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OP_START;
  logic [3:0]  codec_slot_i = '0;
  logic [31:0] response_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_kind_o;
  logic [31:0] verb_word_o;
  logic [31:0] root_vendor_o;
  logic [2:0]  audio_groups_o;
  logic [8:0]  dac_count_o;
  logic [8:0]  adc_count_o;
  logic [8:0]  pin_count_o;
  logic [8:0]  amp_count_o;
  logic [14:0] conn_len_sum_o;
  logic [8:0]  conn_read_count_o;

  int fail_count;
  int pending_beats;
  int beats_sent = 0;
  int answers_left = 0;
  bit no_idle = 1'b0;

  hda_codec_enumeration_sequencer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .codec_slot_i      (codec_slot_i),
    .response_i        (response_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (out_kind_o),
    .verb_word_o       (verb_word_o),
    .root_vendor_o     (root_vendor_o),
    .audio_groups_o    (audio_groups_o),
    .dac_count_o       (dac_count_o),
    .adc_count_o       (adc_count_o),
    .pin_count_o       (pin_count_o),
    .amp_count_o       (amp_count_o),
    .conn_len_sum_o    (conn_len_sum_o),
    .conn_read_count_o (conn_read_count_o)
  );

  hces_walk_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .codec_slot_i      (codec_slot_i),
    .response_i        (response_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (out_kind_o),
    .verb_word_o       (verb_word_o),
    .root_vendor_o     (root_vendor_o),
    .audio_groups_o    (audio_groups_o),
    .dac_count_o       (dac_count_o),
    .adc_count_o       (adc_count_o),
    .pin_count_o       (pin_count_o),
    .amp_count_o       (amp_count_o),
    .conn_len_sum_o    (conn_len_sum_o),
    .conn_read_count_o (conn_read_count_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending_beats)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the output at random, except during the no-idle stretch
  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 35);
  end

  // Offer one input beat, with random idle cycles ahead of it, and hold it until taken
  task automatic send_beat(input logic op, input logic [3:0] slot, input logic [31:0] word);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    codec_slot_i <= slot;
    response_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  task automatic start_walk(input logic [3:0] slot);
    send_beat(OP_START, slot, $urandom);
  endtask

  task automatic respond(input logic [31:0] word);
    send_beat(OP_RESPONSE, 4'($urandom), word);
  endtask

  // Send one codec response; drop it once the walk is cut short, sometimes time out
  task automatic answer(input logic [31:0] word);
    if (answers_left == 0) return;
    answers_left--;
    respond(($urandom_range(39) == 0) ? 32'h0 : word);
  endtask

  // Play one codec through a whole walk, in the order the sequencer asks
  task automatic run_codec_walk();
    logic [3:0]  slot;
    logic [31:0] word;
    logic [31:0] caps;
    int          n_groups;
    int          n_widgets;
    slot = ($urandom_range(19) == 0) ? 4'(DEF_NUM_SLOTS) : 4'($urandom_range(DEF_NUM_SLOTS - 1));
    answers_left = ($urandom_range(7) == 0) ? $urandom_range(1, 30) : 1 << 30;
    start_walk(slot);
    if (slot >= DEF_NUM_SLOTS) return;
    word = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
    answer(word);
    if (word == '0) return;
    answer($urandom);
    // root sub-node count: mostly a short valid list
    word = $urandom;
    case ($urandom_range(9))
      0: word[23:16] = '0;
      1: word[7:0] = '0;
      2: ;
      default: begin
        word[23:16] = 8'($urandom_range(1, 255));
        word[7:0] = 8'($urandom_range(1, 5));
      end
    endcase
    answer(word);
    if (word[23:16] == '0 || word[7:0] == '0) return;
    n_groups = (word[7:0] > DEF_MAX_GROUPS) ? DEF_MAX_GROUPS : word[7:0];
    for (int g = 0; g < n_groups; g++) begin
      word = $urandom;
      if ($urandom_range(2) != 0) word[6:0] = FG_AUDIO;
      answer(word);
      if (word[6:0] != FG_AUDIO) continue;
      word = $urandom;
      word[7:0] = ($urandom_range(39) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      answer(word);
      n_widgets = (word[7:0] > DEF_MAX_WIDGETS) ? DEF_MAX_WIDGETS : word[7:0];
      for (int w = 0; w < n_widgets; w++) begin
        caps = $urandom;
        case ($urandom_range(3))
          0: caps[23:20] = WT_AUDIO_OUT;
          1: caps[23:20] = WT_AUDIO_IN;
          2: caps[23:20] = WT_PIN;
          default: ;
        endcase
        answer(caps);
        if (caps[1]) answer($urandom);
        if (caps[2]) answer($urandom);
        if (caps[8]) begin
          word = $urandom;
          if ($urandom_range(3) == 0) word[6:0] = '0;
          answer(word);
          if (word[6:0] != '0) answer(($urandom_range(3) == 0) ? 32'h0 : $urandom);
        end
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("hda_codec_enumeration_sequencer_test: FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Response with no walk running
    respond(32'hFFFF_FFFF);
    // Slot out of range
    start_walk(4'd15);
    // Absent vendor
    start_walk(4'd0);
    respond(32'h0);
    // Root with start node 0
    start_walk(4'd14);
    respond(32'hFFFF_FFFF);
    respond(32'h0);
    respond(32'h0000_0005);
    // Start during a run, then an empty root
    start_walk(4'd7);
    respond(32'h10EC_0888);
    start_walk(4'd7);
    respond(32'h0000_0001);
    respond(32'h0010_0101);
    respond(32'h00FF_0000);
    // Full walk with node numbers wrapping past 0xFF
    start_walk(4'd9);
    respond(32'h8086_2805);
    respond(32'h0010_0100);
    respond(32'h00FF_0003);
    respond(32'h0000_0002);    // non-audio group, skipped
    respond(32'hFFFF_FF81);    // audio group
    respond(32'h00FE_0003);
    respond(32'h0000_0106);    // output widget with both amps and a list
    respond(32'h8000_0000);
    respond(32'h8000_0000);
    respond(32'hFFFF_FFFF);    // list length 0x7F
    respond(32'h0000_0012);
    respond(32'h0010_0000);    // input widget, no amps
    respond(32'h0040_0100);    // pin with a list
    respond(32'h0000_0080);    // length zero in the low bits
    respond(32'h0);            // timed-out group type

    // Random walks, with one stretch where neither side idles
    while (beats_sent < 570) begin
      no_idle = (beats_sent >= 250 && beats_sent < 350);
      run_codec_walk();
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 2)) respond($urandom);
      end
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then give trailing beats time to show up
    while (pending_beats != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("hda_codec_enumeration_sequencer_test: PASS");
    end else begin
      $display("hda_codec_enumeration_sequencer_test: FAIL");
    end
    $finish;
  end

endmodule
